// ----- sv/base64_custom_alphabet_encoder_core_defines.svh -----
// ----------------------------------------------------------------------------
// base64 encoder assertion macros
// property wrappers used by the encoder's emit block
// ----------------------------------------------------------------------------
`ifndef BASE64_CUSTOM_ALPHABET_ENCODER_CORE_DEFINES_SVH
`define BASE64_CUSTOM_ALPHABET_ENCODER_CORE_DEFINES_SVH

// same-cycle implication
`define B64E_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define B64E_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/b64e_pkg.sv -----
// ----------------------------------------------------------------------------
// b64e_pkg
// types, codes and the character mapping of the base64 encoder
// ----------------------------------------------------------------------------
package b64e_pkg;

	localparam int BYTE_W = 8;
	localparam int SYM_W  = 6;
	localparam int CHAR_W = 7;
	localparam int LEFT_W = 4;

	localparam logic [CHAR_W-1:0] CH_DIGIT_OFS = 7'h30; // '0'
	localparam logic [CHAR_W-1:0] CH_LOWER_OFS = 7'd87; // 'a' - 10
	localparam logic [CHAR_W-1:0] CH_UPPER_OFS = 7'd29; // 'A' - 36
	localparam logic [CHAR_W-1:0] CH_USCORE    = 7'h5f; // '_'
	localparam logic [CHAR_W-1:0] CH_MINUS     = 7'h2d; // '-'

	localparam logic [SYM_W-1:0] SYM_LOWER_LO = 6'd10;
	localparam logic [SYM_W-1:0] SYM_UPPER_LO = 6'd36;
	localparam logic [SYM_W-1:0] SYM_USCORE   = 6'd62;

	// position of the next byte inside its three-byte group
	typedef enum logic [2:0] {
		PH_FIRST  = 3'b001,
		PH_SECOND = 3'b010,
		PH_THIRD  = 3'b100
	} phase_t;

	// one or two characters produced by one input item
	typedef struct packed {
		logic [CHAR_W-1:0] char0;
		logic [CHAR_W-1:0] char1;
		logic              two;
		logic              last;
	} pair_t;

	function automatic logic [CHAR_W-1:0] sym_char(input logic [SYM_W-1:0] v);
		logic [CHAR_W-1:0] vx;
		vx = {1'b0, v};
		if (v < SYM_LOWER_LO)
			return vx + CH_DIGIT_OFS;
		else if (v < SYM_UPPER_LO)
			return vx + CH_LOWER_OFS;
		else if (v < SYM_USCORE)
			return vx + CH_UPPER_OFS;
		else if (v == SYM_USCORE)
			return CH_USCORE;
		else
			return CH_MINUS;
	endfunction

endpackage

// ----- sv/b64e_split.sv -----
// ----------------------------------------------------------------------------
// b64e_split
// group phase and leftover bits, splits each byte into mapped characters
// ----------------------------------------------------------------------------
module b64e_split (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic [b64e_pkg::BYTE_W-1:0] data_byte,
	input  logic                        final_byte,
	output b64e_pkg::pair_t             pair
);
	import b64e_pkg::*;

	phase_t            phase_q;
	phase_t            phase_d;
	logic [LEFT_W-1:0] left_q;
	logic [LEFT_W-1:0] left_d;
	logic [SYM_W-1:0]  sym0;
	logic [SYM_W-1:0]  sym1;

	always_comb begin
		sym0      = data_byte[7:2];
		sym1      = {data_byte[1:0], 4'b0000};
		pair.two  = final_byte;
		pair.last = final_byte;
		left_d    = {2'b00, data_byte[1:0]};
		phase_d   = PH_SECOND;
		case (phase_q)
			PH_SECOND: begin
				sym0    = {left_q[1:0], data_byte[7:4]};
				sym1    = {data_byte[3:0], 2'b00};
				left_d  = data_byte[3:0];
				phase_d = PH_THIRD;
			end
			PH_THIRD: begin
				sym0     = {left_q, data_byte[7:6]};
				sym1     = data_byte[5:0];
				pair.two = 1'b1;
				left_d   = '0;
				phase_d  = PH_FIRST;
			end
			default: begin
			end
		endcase
		if (final_byte) begin
			left_d  = '0;
			phase_d = PH_FIRST;
		end
		pair.char0 = sym_char(sym0);
		pair.char1 = sym_char(sym1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			left_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			left_q  <= left_d;
		end
	end

endmodule

// ----- sv/b64e_emit.sv -----
// ----------------------------------------------------------------------------
// b64e_emit
// result register holding one or two characters, sent one item at a time
// ----------------------------------------------------------------------------
`include "base64_custom_alphabet_encoder_core_defines.svh"

module b64e_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  b64e_pkg::pair_t             pair,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [b64e_pkg::CHAR_W-1:0] out_char,
	output logic                        out_last
);
	import b64e_pkg::*;

	pair_t pair_q;
	logic  valid_q;
	logic  idx_q;
	logic  on_final;
	logic  out_fire;
	logic  in_fire;

	// second character pending or single-character pair
	assign on_final  = idx_q || !pair_q.two;
	assign out_fire  = valid_q && out_ready;
	assign in_ready  = !valid_q || (out_ready && on_final);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = valid_q;
	assign out_char  = idx_q ? pair_q.char1 : pair_q.char0;
	assign out_last  = pair_q.last && on_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 1'b0;
		end else if (in_fire) begin
			valid_q <= 1'b1;
			idx_q   <= 1'b0;
		end else if (out_fire) begin
			if (on_final) begin
				valid_q <= 1'b0;
				idx_q   <= 1'b0;
			end else begin
				idx_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pair_q <= pair;
		end
	end

	`B64E_ASSERT_NOW(a_stall_holds, clk, arst_n, !in_ready, valid_q, "stall without a held item")
	`B64E_ASSERT_NOW(a_idx_two, clk, arst_n, idx_q, pair_q.two && valid_q, "second slot on a single pair")
	`B64E_ASSERT_NEXT(a_second_follows, clk, arst_n, out_fire && !on_final, valid_q && idx_q, "second character lost")
	`B64E_ASSERT_NEXT(a_load_first, clk, arst_n, in_fire, valid_q && !idx_q, "new item not loaded at first slot")

endmodule

// ----- sv/base64_custom_alphabet_encoder_core.sv -----
// ----------------------------------------------------------------------------
// base64_custom_alphabet_encoder_core
// unpadded base64-style encoder with a digits-lower-upper alphabet
// ----------------------------------------------------------------------------
// s_axis carries one raw byte per item, tlast marks the final byte of a stream.
// m_axis carries one ASCII character per item, tlast on the stream's final
// character. An empty stream produces nothing.
// each byte gives one character, the third byte of a group gives two, and a
// final byte inside a group adds one flush character holding the leftover bits.
// a byte's first character is offered in the cycle after the byte is taken.
// throughput: one byte per cycle while each byte gives one character and m_axis is ready; a
// byte giving two characters holds the single result register until both have
// left, so full groups are bound by the output port.
// the next byte is taken in the same cycle the last pending character leaves.
// reset clears the group phase, the leftover bits and the result register's valid flag and slot index.
// when m_axis stalls the held character stays stable and s_axis_tready falls
// once the result register is full.
// ----------------------------------------------------------------------------
module base64_custom_alphabet_encoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
	input  logic       s_axis_tlast,  // final_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [6:0] out_char, [7] zero
	output logic       m_axis_tlast   // out_last
);
	import b64e_pkg::*;

	pair_t             pair;
	logic              in_fire;
	logic [CHAR_W-1:0] out_char;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	b64e_split u_split (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (in_fire),
		.data_byte  (s_axis_tdata),
		.final_byte (s_axis_tlast),
		.pair       (pair)
	);

	b64e_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.pair      (pair),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (out_char),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, out_char};

endmodule

// ----- tb/base64_custom_alphabet_encoder_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_custom_alphabet_encoder_core_test
// streams of raw bytes go in with tlast on the final byte of each stream. Every
// character that comes out is checked against a software encoder that keeps its
// own group phase and carry bits. The input side idles in random bursts, the
// output side stalls on a changing pattern, with one long output hold-off and
// one point where input waits until every character has been drained.
// ----------------------------------------------------------------------------
module base64_custom_alphabet_encoder_core_test;

	localparam int HALF_PERIOD  = 5;
	localparam int STREAM_BYTES = 1800;
	localparam int HOLD_AT      = 600;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_AT     = 1200;
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 10;

	typedef struct {
		logic [b64e_pkg::CHAR_W-1:0] ch;
		logic                        last;
	} enc_char_t;

	// software encoder and the queue of characters still owed by the block
	class char_scoreboard;
		logic [1:0] phase = 2'd0;
		logic [3:0] carry = 4'd0;
		enc_char_t  owed_q[$];
		int         failures = 0;

		function automatic logic [b64e_pkg::CHAR_W-1:0] alphabet_char(input logic [5:0] v);
			int code;
			if (v < 10)
				code = "0" + v;
			else if (v < 36)
				code = "a" + (v - 10);
			else if (v < 62)
				code = "A" + (v - 36);
			else if (v == 62)
				code = "_";
			else
				code = "-";
			return code[b64e_pkg::CHAR_W-1:0];
		endfunction

		function automatic void owe(input logic [5:0] v, input logic last);
			enc_char_t c;
			c.ch   = alphabet_char(v);
			c.last = last;
			owed_q.push_back(c);
		endfunction

		function automatic void note_byte(input logic [7:0] b, input logic fin);
			case (phase)
				2'd1: begin
					owe({carry[1:0], b[7:4]}, 1'b0);
					carry = b[3:0];
					phase = 2'd2;
					if (fin)
						owe({b[3:0], 2'b00}, 1'b1);
				end
				2'd2: begin
					owe({carry[3:0], b[7:6]}, 1'b0);
					owe(b[5:0], fin);
					carry = 4'd0;
					phase = 2'd0;
				end
				default: begin
					// an unused phase value behaves as the start of a group
					owe(b[7:2], 1'b0);
					carry = {2'b00, b[1:0]};
					phase = 2'd1;
					if (fin)
						owe({b[1:0], 4'b0000}, 1'b1);
				end
			endcase
			if (fin) begin
				phase = 2'd0;
				carry = 4'd0;
			end
		endfunction

		function automatic void check_char(input logic [7:0] data, input logic last);
			enc_char_t exp_c;
			if (owed_q.size() == 0) begin
				$error("out_char: nothing expected, actual %h last %b", data, last);
				failures++;
				return;
			end
			exp_c = owed_q.pop_front();
			if (data !== {1'b0, exp_c.ch}) begin
				$error("out_char: expected %h, actual %h", {1'b0, exp_c.ch}, data);
				failures++;
			end
			if (last !== exp_c.last) begin
				$error("out_last: expected %b, actual %b", exp_c.last, last);
				failures++;
			end
		endfunction

		function automatic int pending();
			return owed_q.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;

	char_scoreboard sb;
	int             bytes_taken;
	int             burst_left;
	int             idle_cycles;

	// directed streams: extremes, every group position for the final byte,
	// the underscore and minus codes, and zero bytes
	logic [7:0] dir_data [0:22] = '{
		8'h00, 8'hff, 8'hf8, 8'hfc, 8'h24, 8'h8e, 8'hf5, 8'h28, 8'h8c, 8'h24, 8'hf7,
		8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h55, 8'haa, 8'h91, 8'h7e, 8'hdb,
		8'hfe
	};
	logic       dir_fin  [0:22] = '{
		1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
		1'b1
	};

	base64_custom_alphabet_encoder_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// both sides observed at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				sb.note_byte(s_axis_tdata, s_axis_tlast);
				bytes_taken++;
			end
			if (m_axis_tvalid && m_axis_tready)
				sb.check_char(m_axis_tdata, m_axis_tlast);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// receiver: random stall pattern with a changing mode, plus one long hold-off
	initial begin
		int  mode;
		int  mode_left;
		int  tick;
		bit  held;
		m_axis_tready = 1'b0;
		mode      = 0;
		mode_left = 0;
		tick      = 0;
		held      = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && bytes_taken >= HOLD_AT) begin
				held = 1'b1;
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			tick++;
			case (mode)
				0: m_axis_tready = 1'b1;
				1: m_axis_tready = 1'($urandom_range(0, 1));
				2: m_axis_tready = (tick % 3) != 0;
				default: m_axis_tready = ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// entered and left just after a falling edge
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				s_axis_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = b;
		s_axis_tlast  = fin;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int  len;
		int  sent;
		bit  drained;
		sb            = new;
		bytes_taken   = 0;
		burst_left    = 0;
		idle_cycles   = 0;
		sent          = 0;
		drained       = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tlast  = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < 23; i++) begin
			send_byte(dir_data[i], dir_fin[i]);
			sent++;
		end

		while (sent < STREAM_BYTES) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 8);
			for (int k = 1; k <= len; k++) begin
				send_byte(8'($urandom_range(0, 255)), k == len);
				sent++;
			end
			if (!drained && sent >= DRAIN_AT) begin
				drained = 1'b1;
				wait_drained();
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
